>>> sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers on clk / rst_n; empty when SYNTHESIS is set.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define ASSERT_ON_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_ON_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/vsoc_pkg.sv
// ============================================================================
// vsoc_pkg
// Shared constants and types of the voxel sphere occupancy counter.
// ============================================================================
package vsoc_pkg;

    localparam int MAX_DIM_DEF = 64;

    // config register indexes
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic [6:0] SIZE_RST = 7'd64;

    // voxel classes
    localparam logic [1:0] CLS_EMPTY = 2'd0;
    localparam logic [1:0] CLS_BARK  = 2'd2;

    // sphere of radius 2: 33 lattice points, z outer, x inner
    localparam int NUM_PTS = 33;
    localparam int IDX_W   = $clog2(NUM_PTS + 1);
    localparam logic [IDX_W-1:0] CENTER_IDX = IDX_W'(16);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_PTS);

    localparam logic [31:0] HASH_MUL = 32'h9E3779B1;

    typedef struct packed {
        logic signed [2:0] dz;
        logic signed [2:0] dy;
        logic signed [2:0] dx;
    } vsoc_ofs_t;

    localparam vsoc_ofs_t PT_OFS [NUM_PTS] = '{
        '{-3'sd2,  3'sd0,  3'sd0},
        '{-3'sd1, -3'sd1, -3'sd1}, '{-3'sd1, -3'sd1,  3'sd0}, '{-3'sd1, -3'sd1,  3'sd1},
        '{-3'sd1,  3'sd0, -3'sd1}, '{-3'sd1,  3'sd0,  3'sd0}, '{-3'sd1,  3'sd0,  3'sd1},
        '{-3'sd1,  3'sd1, -3'sd1}, '{-3'sd1,  3'sd1,  3'sd0}, '{-3'sd1,  3'sd1,  3'sd1},
        '{ 3'sd0, -3'sd2,  3'sd0},
        '{ 3'sd0, -3'sd1, -3'sd1}, '{ 3'sd0, -3'sd1,  3'sd0}, '{ 3'sd0, -3'sd1,  3'sd1},
        '{ 3'sd0,  3'sd0, -3'sd2}, '{ 3'sd0,  3'sd0, -3'sd1}, '{ 3'sd0,  3'sd0,  3'sd0},
        '{ 3'sd0,  3'sd0,  3'sd1}, '{ 3'sd0,  3'sd0,  3'sd2},
        '{ 3'sd0,  3'sd1, -3'sd1}, '{ 3'sd0,  3'sd1,  3'sd0}, '{ 3'sd0,  3'sd1,  3'sd1},
        '{ 3'sd0,  3'sd2,  3'sd0},
        '{ 3'sd1, -3'sd1, -3'sd1}, '{ 3'sd1, -3'sd1,  3'sd0}, '{ 3'sd1, -3'sd1,  3'sd1},
        '{ 3'sd1,  3'sd0, -3'sd1}, '{ 3'sd1,  3'sd0,  3'sd0}, '{ 3'sd1,  3'sd0,  3'sd1},
        '{ 3'sd1,  3'sd1, -3'sd1}, '{ 3'sd1,  3'sd1,  3'sd0}, '{ 3'sd1,  3'sd1,  3'sd1},
        '{ 3'sd2,  3'sd0,  3'sd0}
    };

endpackage

>>> sv/vsoc_store.sv
// ============================================================================
// vsoc_store
// Voxel class memory with a clearing sweep after reset and registered read.
// ============================================================================
module vsoc_store #(
    parameter int MAX_DIM = vsoc_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [3*$clog2(MAX_DIM)-1:0]   addr,
    input  logic [1:0]                     wdata,
    output logic [1:0]                     rd_data,
    output logic                           rdy
);
    import vsoc_pkg::*;

    localparam int AXW    = $clog2(MAX_DIM);
    localparam int ADDR_W = 3 * AXW;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [1:0]        mem [DEPTH];
    logic [1:0]        rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clearing_reg;

    // sweep every entry to empty, one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= CLS_EMPTY;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;
    assign rdy     = !clearing_reg;

endmodule

>>> sv/voxel_sphere_occupancy_count_top.sv
// ============================================================================
// voxel_sphere_occupancy_count_top
// Voxel class store with max-merge writes and radius-2 occupancy queries.
// ============================================================================
// Query in grid: 33 point reads through the registered store read, then the
//   output load; the next word is taken after that; a held result stalls.
// Merge: read, then write the larger class. Out-of-grid query: output load only.
// Out-of-grid merge: dropped, no word out. in_ready drops while an item runs.
// Reset: sizes go to 64, then a clearing sweep of all 2^(3*clog2(MAX_DIM)) entries
//   (262144 at MAX_DIM 64) empties the store; no word is taken meanwhile.
`include "assert_macros.svh"

module voxel_sphere_occupancy_count_top #(
    parameter int MAX_DIM = vsoc_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [6:0]  cfg_wdata,
    // input word
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [5:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [5:0]  pos_z,
    input  logic [1:0]  new_class,
    // result word
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  cell_class,
    output logic [5:0]  occupied_count,
    output logic [15:0] jitter,
    output logic        out_of_range
);
    import vsoc_pkg::*;

    localparam int AXW    = $clog2(MAX_DIM);
    localparam int ADDR_W = 3 * AXW;

    // sizes above MAX_DIM saturate; a 7-bit register never exceeds 127
    localparam logic [6:0] DIM_SAT = (MAX_DIM > 127) ? 7'd127 : 7'(MAX_DIM);

    // jitter multiply steps, run during the first sweep cycles
    localparam logic [IDX_W-1:0] STEP_SXSY = IDX_W'(0);
    localparam logic [IDX_W-1:0] STEP_ZTRM = IDX_W'(1);
    localparam logic [IDX_W-1:0] STEP_YTRM = IDX_W'(2);
    localparam logic [IDX_W-1:0] STEP_HASH = IDX_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MRD,
        ST_MWR,
        ST_QRY,
        ST_QDONE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             pt_ok_reg;
    logic             pt_ctr_reg;
    logic [5:0]       occ_reg;
    logic [1:0]       cls_reg;
    logic             out_valid_reg;

    logic [6:0] size_x_reg, size_y_reg, size_z_reg;

    // payload
    logic [5:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic [1:0]  cls_new_reg;
    logic        oor_reg;
    logic [23:0] lin_reg;
    logic [23:0] mul_reg;
    logic [1:0]  out_cls_reg;
    logic [5:0]  out_occ_reg;
    logic [15:0] out_jit_reg;
    logic        out_oor_reg;

    logic [6:0]  sx, sy, sz;
    logic        in_acc;
    logic        in_grid;
    logic        load_out;
    vsoc_ofs_t   ofs;
    logic [7:0]  px, py, pz;
    logic        pt_in;
    logic [ADDR_W-1:0] mem_addr;
    logic        mem_we;
    logic [1:0]  mem_wdata;
    logic [1:0]  rd_data;
    logic        store_rdy;
    logic [23:0] mul_a, mul_b, prod;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RST;
            size_y_reg <= SIZE_RST;
            size_z_reg <= SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SIZE_X: size_x_reg <= cfg_wdata;
                REG_SIZE_Y: size_y_reg <= cfg_wdata;
                REG_SIZE_Z: size_z_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign sx = (size_x_reg > DIM_SAT) ? DIM_SAT : size_x_reg;
    assign sy = (size_y_reg > DIM_SAT) ? DIM_SAT : size_y_reg;
    assign sz = (size_z_reg > DIM_SAT) ? DIM_SAT : size_z_reg;

    assign in_ready = (state_reg == ST_IDLE) && store_rdy;
    assign in_acc   = in_valid && in_ready;
    assign in_grid  = ({1'b0, pos_x} < sx) && ({1'b0, pos_y} < sy) && ({1'b0, pos_z} < sz);
    assign load_out = (state_reg == ST_QDONE) && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // Shared coordinate adder: sphere point during the sweep, cell itself
    // otherwise. Coordinates stay below 66, so bit 7 flags a negative one.
    // ------------------------------------------------------------------
    assign ofs = ((state_reg == ST_QRY) && (idx_reg < LAST_IDX)) ? PT_OFS[idx_reg] : '0;

    assign px = {2'b00, pos_x_reg} + {{5{ofs.dx[2]}}, ofs.dx};
    assign py = {2'b00, pos_y_reg} + {{5{ofs.dy[2]}}, ofs.dy};
    assign pz = {2'b00, pos_z_reg} + {{5{ofs.dz[2]}}, ofs.dz};

    assign pt_in = !px[7] && !py[7] && !pz[7] &&
                   (px[6:0] < sx) && (py[6:0] < sy) && (pz[6:0] < sz);

    assign mem_addr  = {pz[AXW-1:0], py[AXW-1:0], px[AXW-1:0]};
    assign mem_we    = (state_reg == ST_MWR);
    assign mem_wdata = (cls_new_reg >= rd_data) ? cls_new_reg : rd_data;

    vsoc_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (mem_we),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rd_data (rd_data),
        .rdy     (store_rdy)
    );

    // ------------------------------------------------------------------
    // Shared multiplier for the hash. Only the low 24 bits matter for
    // bits 23..8 of the product, so everything runs mod 2^24.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_QRY)
        begin
            unique case (idx_reg)
                STEP_SXSY:
                begin
                    mul_a = 24'(sx);
                    mul_b = 24'(sy);
                end
                STEP_ZTRM:
                begin
                    mul_a = 24'(pos_z_reg);
                    mul_b = mul_reg;
                end
                STEP_YTRM:
                begin
                    mul_a = 24'(pos_y_reg);
                    mul_b = 24'(sx);
                end
                STEP_HASH:
                begin
                    mul_a = lin_reg;
                    mul_b = HASH_MUL[23:0];
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod = 24'(mul_a * mul_b);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pt_ok_reg     <= 1'b0;
            pt_ctr_reg    <= 1'b0;
            occ_reg       <= '0;
            cls_reg       <= CLS_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new load in the same cycle keeps the output full
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        occ_reg    <= '0;
                        cls_reg    <= CLS_EMPTY;
                        idx_reg    <= '0;
                        pt_ok_reg  <= 1'b0;
                        pt_ctr_reg <= 1'b0;
                        if (!in_grid)
                        begin
                            // merge outside the grid is dropped
                            state_reg <= action ? ST_QDONE : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= action ? ST_QRY : ST_MRD;
                        end
                    end
                end
                ST_MRD:
                begin
                    state_reg <= ST_MWR;
                end
                ST_MWR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_QRY:
                begin
                    // data of the point issued last cycle
                    if (pt_ok_reg && (rd_data != CLS_EMPTY))
                    begin
                        occ_reg <= occ_reg + 6'd1;
                    end
                    if (pt_ctr_reg)
                    begin
                        cls_reg <= rd_data;
                    end
                    if (idx_reg < LAST_IDX)
                    begin
                        pt_ok_reg  <= pt_in;
                        pt_ctr_reg <= (idx_reg == CENTER_IDX);
                        idx_reg    <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        pt_ok_reg  <= 1'b0;
                        pt_ctr_reg <= 1'b0;
                        state_reg  <= ST_QDONE;
                    end
                end
                ST_QDONE:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            pos_z_reg   <= pos_z;
            cls_new_reg <= (new_class > CLS_BARK) ? CLS_BARK : new_class;
            oor_reg     <= !in_grid;
            mul_reg     <= '0;
        end
        else if (state_reg == ST_QRY)
        begin
            unique case (idx_reg)
                STEP_SXSY: mul_reg <= prod;
                STEP_ZTRM: lin_reg <= prod;
                STEP_YTRM: lin_reg <= lin_reg + prod + 24'(pos_x_reg);
                STEP_HASH: mul_reg <= prod;
                default:   ;
            endcase
        end
        if (load_out)
        begin
            out_cls_reg <= cls_reg;
            out_occ_reg <= occ_reg;
            out_jit_reg <= mul_reg[23:8];
            out_oor_reg <= oor_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_class     = out_cls_reg;
    assign occupied_count = out_occ_reg;
    assign jitter         = out_jit_reg;
    assign out_of_range   = out_oor_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_no_accept_clearing, !store_rdy |-> !in_ready, "word taken while clearing")
    `ASSERT_ON_CLK(a_occ_bound, occ_reg <= 6'(NUM_PTS), "occupancy above sphere size")
    `ASSERT_ON_CLK(a_oor_zero,
        (out_valid && out_of_range) |->
        (cell_class == CLS_EMPTY && occupied_count == 6'd0 && jitter == 16'd0),
        "out-of-range word not zeroed")
    `ASSERT_ON_CLK(a_cls_legal, out_valid |-> (cell_class <= CLS_BARK), "illegal class out")
    `ASSERT_ON_CLK(a_sweep_full,
        (state_reg == ST_QDONE && $past(state_reg) == ST_QRY) |->
        ($past(idx_reg) == LAST_IDX),
        "sweep ended early")

endmodule
